[design/dpfa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpfa_pkg
// Shared constants and codes of the dual-pool first-fit allocator.
// ----------------------------------------------------------------------------
package dpfa_pkg;

  // default arena geometry
  localparam int ARENA_BYTES_DEF  = 4096;
  localparam int HEADER_BYTES_DEF = 16;

  // fixed field widths
  localparam int ADDR_W = 14;
  localparam int SIZE_W = 13;
  localparam int ST_W   = 3;
  localparam int CW     = 16;   // width of address / size arithmetic

  // small arena base address
  localparam int SMALL_BASE = 8192;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int DATA_W = 32;
  localparam logic [0:0]        REG_SMALL_LIMIT = 1'b0;
  localparam logic [SIZE_W-1:0] LIMIT_RESET     = 13'd300;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EXHAUST  = 3'd1;
  localparam logic [ST_W-1:0] ST_NOFIT    = 3'd2;
  localparam logic [ST_W-1:0] ST_OUTSIDE  = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTSTART = 3'd4;
  localparam logic [ST_W-1:0] ST_DOUBLE   = 3'd5;

endpackage
`default_nettype wire

[design/dpfa_hdr_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpfa_hdr_store
// Header memory for both arenas, one read and one write port, registered
// read data. The root header of each arena reads as a full free block until
// it is first written.
// ----------------------------------------------------------------------------
module dpfa_hdr_store #(
  parameter int ARENA_BYTES  = dpfa_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = dpfa_pkg::HEADER_BYTES_DEF,
  parameter int OFF_W        = $clog2(ARENA_BYTES),
  parameter int HW           = 3 * OFF_W + 3
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           rd_en_i,
  input  wire logic [OFF_W:0] rd_addr_i,
  output logic [HW-1:0]       rd_data_o,
  input  wire logic           wr_en_i,
  input  wire logic [OFF_W:0] wr_addr_i,
  input  wire logic [HW-1:0]  wr_data_i
);

  localparam int DEPTH = 2 * ARENA_BYTES;
  // {free, has_prv, has_nxt, prv, nxt, size}
  localparam logic [HW-1:0] ROOT_INIT =
    {1'b1, 1'b0, 1'b0, {OFF_W{1'b0}}, {OFF_W{1'b0}},
     OFF_W'(ARENA_BYTES - HEADER_BYTES)};

  logic [HW-1:0] mem [DEPTH];
  logic [HW-1:0] rd_data_q;
  logic          rd_root_q;
  logic [1:0]    root_wr_q;

  // memory array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // root headers: track first write, flag reads of an untouched root
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_wr_q <= '0;
      rd_root_q <= 1'b0;
    end else begin
      if (wr_en_i && (wr_addr_i[OFF_W-1:0] == '0)) begin
        root_wr_q[wr_addr_i[OFF_W]] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_root_q <= (rd_addr_i[OFF_W-1:0] == '0) && !root_wr_q[rd_addr_i[OFF_W]];
      end
    end
  end

  assign rd_data_o = rd_root_q ? ROOT_INIT : rd_data_q;

endmodule
`default_nettype wire

[design/dpfa_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpfa_seq
// Request sequencer: walks header chains, splits and merges blocks with
// read-modify-write on the header memory, holds the result register.
// ----------------------------------------------------------------------------
module dpfa_seq #(
  parameter int ARENA_BYTES  = dpfa_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = dpfa_pkg::HEADER_BYTES_DEF,
  parameter int OFF_W        = $clog2(ARENA_BYTES),
  parameter int HW           = 3 * OFF_W + 3
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        op_i,
  input  wire logic [dpfa_pkg::SIZE_W-1:0] req_size_i,
  input  wire logic [dpfa_pkg::ADDR_W-1:0] free_addr_i,
  input  wire logic [dpfa_pkg::SIZE_W-1:0] limit_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [dpfa_pkg::ADDR_W-1:0]      result_addr_o,
  output logic [dpfa_pkg::ST_W-1:0]        status_o,
  output logic                             rd_en_o,
  output logic [OFF_W:0]                   rd_addr_o,
  input  wire logic [HW-1:0]               rd_data_i,
  output logic                             wr_en_o,
  output logic [OFF_W:0]                   wr_addr_o,
  output logic [HW-1:0]                    wr_data_o
);

  localparam int CW = dpfa_pkg::CW;
  localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
  localparam logic [CW-1:0] SBASE_C = CW'(dpfa_pkg::SMALL_BASE);

  typedef struct packed {
    logic             free;
    logic             has_prv;
    logic             has_nxt;
    logic [OFF_W-1:0] prv;
    logic [OFF_W-1:0] nxt;
    logic [OFF_W-1:0] size;
  } hdr_t;

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_A_RD = 5'd1;
  localparam logic [4:0] S_A_EV = 5'd2;
  localparam logic [4:0] S_A_SP = 5'd3;
  localparam logic [4:0] S_A_NR = 5'd4;
  localparam logic [4:0] S_A_NW = 5'd5;
  localparam logic [4:0] S_F_RD = 5'd6;
  localparam logic [4:0] S_F_EV = 5'd7;
  localparam logic [4:0] S_P_RD = 5'd8;
  localparam logic [4:0] S_P_EV = 5'd9;
  localparam logic [4:0] S_N_CK = 5'd10;
  localparam logic [4:0] S_C_RD = 5'd11;
  localparam logic [4:0] S_C_EV = 5'd12;
  localparam logic [4:0] S_D_RD = 5'd13;
  localparam logic [4:0] S_D_EV = 5'd14;
  localparam logic [4:0] S_WB   = 5'd15;
  localparam logic [4:0] S_DONE = 5'd16;

  logic [4:0]                  state_q, state_d;
  logic [dpfa_pkg::SIZE_W-1:0] size_q, size_d;
  logic [dpfa_pkg::ADDR_W-1:0] faddr_q, faddr_d;
  logic                        ar_q, ar_d;
  logic [OFF_W-1:0]            cur_q, cur_d;
  logic [OFF_W-1:0]            qoff_q, qoff_d;
  logic [OFF_W-1:0]            bi_q, bi_d;
  logic [OFF_W-1:0]            dn_q, dn_d;
  logic                        pm_q, pm_d;
  hdr_t                        ah_q, ah_d;
  hdr_t                        bh_q, bh_d;
  logic [dpfa_pkg::ST_W-1:0]   st_q, st_d;
  logic [dpfa_pkg::ADDR_W-1:0] res_q, res_d;
  logic                        out_valid_q;
  logic [dpfa_pkg::ADDR_W-1:0] out_addr_q;
  logic [dpfa_pkg::ST_W-1:0]   out_st_q;

  hdr_t             hp;
  logic             rd_en, wr_en;
  logic [OFF_W-1:0] rd_off, wr_off;
  hdr_t             wr_hdr;
  logic [CW-1:0]    pay_w, q_w, req_w, fa_w;
  logic             in_range, out_load;

  assign hp    = hdr_t'(rd_data_i);
  assign req_w = CW'(size_q);
  // payload address of the header at cur in the current arena
  assign pay_w = (ar_q ? SBASE_C : '0) + CW'(cur_q) + HDR_C;
  // split point
  assign q_w   = CW'(cur_q) + HDR_C + req_w;
  // free address range, arena end inclusive
  assign fa_w     = CW'(free_addr_i);
  assign in_range = (fa_w <= ARENA_C) || ((fa_w >= SBASE_C) && (fa_w <= SBASE_C + ARENA_C));

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // next-state and memory access control
  always_comb begin
    hdr_t tmp;
    tmp     = hp;
    state_d = state_q;
    size_d  = size_q;
    faddr_d = faddr_q;
    ar_d    = ar_q;
    cur_d   = cur_q;
    qoff_d  = qoff_q;
    bi_d    = bi_q;
    dn_d    = dn_q;
    pm_d    = pm_q;
    ah_d    = ah_q;
    bh_d    = bh_q;
    st_d    = st_q;
    res_d   = res_q;
    rd_en   = 1'b0;
    rd_off  = cur_q;
    wr_en   = 1'b0;
    wr_off  = cur_q;
    wr_hdr  = hp;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          size_d  = req_size_i;
          faddr_d = free_addr_i;
          cur_d   = '0;
          res_d   = '0;
          st_d    = dpfa_pkg::ST_OK;
          if (op_i == dpfa_pkg::OP_ALLOC) begin
            ar_d    = (req_size_i < limit_i);
            state_d = S_A_RD;
          end else if (!in_range) begin
            st_d    = dpfa_pkg::ST_OUTSIDE;
            state_d = S_DONE;
          end else begin
            ar_d    = 1'b0;
            state_d = S_F_RD;
          end
        end
      end
      S_A_RD: begin
        rd_en   = 1'b1;
        state_d = S_A_EV;
      end
      S_A_EV: begin
        if (CW'(hp.size) < req_w || !hp.free) begin
          st_d = (CW'(hp.size) < req_w) ? dpfa_pkg::ST_EXHAUST : dpfa_pkg::ST_NOFIT;
          if (hp.has_nxt) begin
            cur_d   = hp.nxt;
            state_d = S_A_RD;
          end else begin
            res_d   = '0;
            state_d = S_DONE;
          end
        end else if (CW'(hp.size) < req_w + HDR_C) begin
          // whole block handed over
          tmp.free = 1'b0;
          wr_en    = 1'b1;
          wr_hdr   = tmp;
          st_d     = dpfa_pkg::ST_OK;
          res_d    = pay_w[dpfa_pkg::ADDR_W-1:0];
          state_d  = S_DONE;
        end else if (q_w >= ARENA_C) begin
          st_d    = dpfa_pkg::ST_EXHAUST;
          res_d   = '0;
          state_d = S_DONE;
        end else begin
          // split: write the new free remainder header
          tmp.free    = 1'b1;
          tmp.has_prv = 1'b1;
          tmp.prv     = cur_q;
          tmp.size    = OFF_W'(CW'(hp.size) - HDR_C - req_w);
          wr_en       = 1'b1;
          wr_off      = q_w[OFF_W-1:0];
          wr_hdr      = tmp;
          ah_d        = hp;
          qoff_d      = q_w[OFF_W-1:0];
          st_d        = dpfa_pkg::ST_OK;
          res_d       = pay_w[dpfa_pkg::ADDR_W-1:0];
          state_d     = S_A_SP;
        end
      end
      S_A_SP: begin
        tmp         = ah_q;
        tmp.size    = size_q[OFF_W-1:0];
        tmp.nxt     = qoff_q;
        tmp.has_nxt = 1'b1;
        tmp.free    = 1'b0;
        wr_en       = 1'b1;
        wr_hdr      = tmp;
        state_d     = ah_q.has_nxt ? S_A_NR : S_DONE;
      end
      S_A_NR: begin
        rd_en   = 1'b1;
        rd_off  = ah_q.nxt;
        state_d = S_A_NW;
      end
      S_A_NW: begin
        tmp.prv     = qoff_q;
        tmp.has_prv = 1'b1;
        wr_en       = 1'b1;
        wr_off      = ah_q.nxt;
        wr_hdr      = tmp;
        state_d     = S_DONE;
      end
      S_F_RD: begin
        rd_en   = 1'b1;
        state_d = S_F_EV;
      end
      S_F_EV: begin
        if (pay_w == CW'(faddr_q)) begin
          ah_d = hp;
          bi_d = cur_q;
          if (hp.free) begin
            st_d    = dpfa_pkg::ST_DOUBLE;
            state_d = S_DONE;
          end else if (hp.has_prv) begin
            state_d = S_P_RD;
          end else begin
            tmp.free = 1'b1;
            bh_d     = tmp;
            pm_d     = 1'b0;
            state_d  = S_N_CK;
          end
        end else if (hp.has_nxt) begin
          cur_d   = hp.nxt;
          state_d = S_F_RD;
        end else if (!ar_q) begin
          ar_d    = 1'b1;
          cur_d   = '0;
          state_d = S_F_RD;
        end else begin
          st_d    = dpfa_pkg::ST_NOTSTART;
          state_d = S_DONE;
        end
      end
      S_P_RD: begin
        rd_en   = 1'b1;
        rd_off  = ah_q.prv;
        state_d = S_P_EV;
      end
      S_P_EV: begin
        if (hp.free) begin
          // absorb into the free previous block
          tmp.size    = OFF_W'(CW'(hp.size) + HDR_C + CW'(ah_q.size));
          tmp.nxt     = ah_q.nxt;
          tmp.has_nxt = ah_q.has_nxt;
          bh_d        = tmp;
          bi_d        = ah_q.prv;
          pm_d        = 1'b1;
        end else begin
          tmp      = ah_q;
          tmp.free = 1'b1;
          bh_d     = tmp;
          pm_d     = 1'b0;
        end
        state_d = S_N_CK;
      end
      S_N_CK: begin
        state_d = ah_q.has_nxt ? S_C_RD : S_WB;
      end
      S_C_RD: begin
        rd_en   = 1'b1;
        rd_off  = ah_q.nxt;
        state_d = S_C_EV;
      end
      S_C_EV: begin
        if (hp.free) begin
          // absorb the free next block
          tmp         = bh_q;
          tmp.size    = OFF_W'(CW'(bh_q.size) + HDR_C + CW'(hp.size));
          tmp.nxt     = hp.nxt;
          tmp.has_nxt = hp.has_nxt;
          tmp.free    = 1'b1;
          bh_d        = tmp;
          dn_d        = hp.nxt;
          state_d     = hp.has_nxt ? S_D_RD : S_WB;
        end else begin
          if (pm_q) begin
            tmp.prv     = bi_q;
            tmp.has_prv = 1'b1;
            wr_en       = 1'b1;
            wr_off      = ah_q.nxt;
            wr_hdr      = tmp;
          end
          state_d = S_WB;
        end
      end
      S_D_RD: begin
        rd_en   = 1'b1;
        rd_off  = dn_q;
        state_d = S_D_EV;
      end
      S_D_EV: begin
        tmp.prv     = bi_q;
        tmp.has_prv = 1'b1;
        wr_en       = 1'b1;
        wr_off      = dn_q;
        wr_hdr      = tmp;
        state_d     = S_WB;
      end
      S_WB: begin
        wr_en   = 1'b1;
        wr_off  = bi_q;
        wr_hdr  = bh_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rd_en_o   = rd_en;
  assign rd_addr_o = {ar_q, rd_off};
  assign wr_en_o   = wr_en;
  assign wr_addr_o = {ar_q, wr_off};
  assign wr_data_o = wr_hdr;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    faddr_q <= faddr_d;
    ar_q    <= ar_d;
    cur_q   <= cur_d;
    qoff_q  <= qoff_d;
    bi_q    <= bi_d;
    dn_q    <= dn_d;
    pm_q    <= pm_d;
    ah_q    <= ah_d;
    bh_q    <= bh_d;
    st_q    <= st_d;
    res_q   <= res_d;
    if (out_load) begin
      out_addr_q <= (st_q == dpfa_pkg::ST_OK) ? res_q : '0;
      out_st_q   <= st_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_addr_o = out_addr_q;
  assign status_o      = out_st_q;

endmodule
`default_nettype wire

[design/dual_pool_first_fit_allocator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dual_pool_first_fit_allocator_top
// First-fit allocator over a large arena (base 0) and a small arena
// (base 8192) with splitting, free checks and neighbor coalescing.
// ----------------------------------------------------------------------------
// One request at a time. Every header visited takes a memory read state, then
// an evaluate state; the header memory has one read and one write port. An
// allocate walks the headers of one arena; a split adds a rewrite of the
// allocated header and, if a block follows, a read and rewrite of that block
// to relink it. A free may walk the whole large chain before the small one,
// then reads the previous and next neighbors as present, the block after a
// merged next neighbor, and writes the header back. With the default 4096-byte
// arenas and 16-byte headers a chain holds at most 256 blocks. The next request
// is taken while a finished result still waits on the output. Both arena roots
// are valid right after reset; no initialization pass is needed.
module dual_pool_first_fit_allocator_top #(
  parameter int ARENA_BYTES  = dpfa_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = dpfa_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          op_i,
  input  wire logic [dpfa_pkg::SIZE_W-1:0]   req_size_i,
  input  wire logic [dpfa_pkg::ADDR_W-1:0]   free_addr_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [dpfa_pkg::ADDR_W-1:0]        result_addr_o,
  output logic [dpfa_pkg::ST_W-1:0]          status_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dpfa_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [dpfa_pkg::DATA_W-1:0]   pwdata,
  output logic [dpfa_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int OFF_W = $clog2(ARENA_BYTES);
  localparam int HW    = 3 * OFF_W + 3;

  logic [dpfa_pkg::SIZE_W-1:0] limit_q;
  logic                        rd_en, wr_en;
  logic [OFF_W:0]              rd_addr, wr_addr;
  logic [HW-1:0]               rd_data, wr_data;
  logic                        reg_sel;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == dpfa_pkg::REG_SMALL_LIMIT);
  assign prdata  = reg_sel ? dpfa_pkg::DATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= dpfa_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      limit_q <= pwdata[dpfa_pkg::SIZE_W-1:0];
    end
  end

  dpfa_hdr_store #(
    .ARENA_BYTES (ARENA_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .OFF_W       (OFF_W),
    .HW          (HW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  dpfa_seq #(
    .ARENA_BYTES (ARENA_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .OFF_W       (OFF_W),
    .HW          (HW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .req_size_i   (req_size_i),
    .free_addr_i  (free_addr_i),
    .limit_i      (limit_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_addr_o(result_addr_o),
    .status_o     (status_o),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

endmodule
`default_nettype wire

[design/dpfa_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpfa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dpfa_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [dpfa_pkg::ADDR_W-1:0] result_addr_o,
  input wire logic [dpfa_pkg::ST_W-1:0]   status_o,
  input wire logic                        pready
);

  // status codes stay in the defined set
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= dpfa_pkg::ST_DOUBLE))
    else $error("status code out of range");

  // a failed transaction reports no address
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != dpfa_pkg::ST_OK)) |-> (result_addr_o == '0))
    else $error("address on failed transaction");

  // a stalled result stays presented
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(result_addr_o)))
    else $error("result dropped while stalled");

  // one request in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction accepted too early");

  // config port never stalls
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind dual_pool_first_fit_allocator_top dpfa_checker u_dpfa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .result_addr_o(result_addr_o),
  .status_o     (status_o),
  .pready       (pready)
);
`default_nettype wire
